>>> rtl/assert_macros.svh
// Assertion helpers for the hash engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst, ante, cons)
`define CHK_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/mmd5_pkg.sv
`default_nettype none
package mmd5_pkg;
  localparam logic [7:0] PAD_FIRST = 8'h91;
  localparam logic [0:0] OP_ABSORB = 1'b0;
  localparam logic [0:0] OP_FINISH = 1'b1;
  localparam logic [31:0] INIT_W [4] = '{32'h71452301, 32'hefcdab79, 32'h98badcae,
    32'h10325496};

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LEN, ST_ROUND, ST_FOLD, ST_OUT
  } state_t;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k [64];
    k = '{
      32'hc76aa478, 32'hf8c7b756, 32'h242070db, 32'hc1bdceee,
      32'he57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return k[r];
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'h0: s = 5'd9;  4'h1: s = 5'd14; 4'h2: s = 5'd19; 4'h3: s = 5'd24;
      4'h4: s = 5'd7;  4'h5: s = 5'd11; 4'h6: s = 5'd16; 4'h7: s = 5'd22;
      4'h8: s = 5'd6;  4'h9: s = 5'd13; 4'ha: s = 5'd18; 4'hb: s = 5'd25;
      4'hc: s = 5'd8;  4'hd: s = 5'd12; 4'he: s = 5'd17; default: s = 5'd23;
    endcase
    return s;
  endfunction

  // Message word index used by round r.
  function automatic logic [3:0] word_sel(input logic [5:0] r);
    logic [3:0] g;
    unique case (r[5:4])
      2'd0: g = r[3:0];
      2'd1: g = 4'(5 * r[3:0] + 1);
      2'd2: g = 4'(3 * r[3:0] + 5);
      default: g = 4'(7 * r[3:0]);
    endcase
    return g;
  endfunction

  typedef struct packed {
    logic        start;
    logic [5:0]  round;
  } rnd_ctl_t;
endpackage
`default_nettype wire

>>> rtl/mmd5_buf.sv
`default_nettype none
// Block buffer: 16 little-endian words with per-byte write enables.
module mmd5_buf (
  input  wire logic        clk,
  input  wire logic        wr_en,
  input  wire logic [5:0]  wr_addr,
  input  wire logic [7:0]  wr_data,
  input  wire logic [3:0]  rd_addr,
  output logic [31:0]      rd_data
);
  import mmd5_pkg::*;
  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[5:2]][8*wr_addr[1:0] +: 8] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

>>> rtl/mmd5_round.sv
`default_nettype none
// Round datapath: one MD5-style round per cycle while step is high, on the working registers.
module mmd5_round (
  input  wire logic               clk,
  input  wire mmd5_pkg::rnd_ctl_t ctl,
  input  wire logic               step,
  input  wire logic [31:0]        init_a,
  input  wire logic [31:0]        init_b,
  input  wire logic [31:0]        init_c,
  input  wire logic [31:0]        init_d,
  input  wire logic [31:0]        word,
  output logic [31:0]             a,
  output logic [31:0]             b,
  output logic [31:0]             c,
  output logic [31:0]             d
);
  import mmd5_pkg::*;
  logic [31:0] f, sum, rot;
  logic [4:0]  s;

  always_comb begin
    unique case (ctl.round[5:4])
      2'd0: f = (b & c) | ((~b & d) ^ c);
      2'd1: f = (b & d) | ((c & ~d) ^ b);
      2'd2: f = b ^ c ^ d ^ (b & c);
      default: f = c ^ (b | ~d) ^ d;
    endcase
    sum = a + f + word + round_k(ctl.round);
    s = rot_amt(ctl.round);
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a <= init_a; b <= init_b; c <= init_c; d <= init_d;
    end else if (step) begin
      a <= d; d <= c; c <= b; b <= b + rot;
    end
  end
endmodule
`default_nettype wire

>>> rtl/modified_md5_hash_engine_unit.sv
`default_nettype none
// Altered-MD5 byte hash engine. Each absorb transfer writes one buffer byte;
// the 64th byte of a block starts 64 rounds in a single shared round unit
// (one per cycle, reading one buffer word per cycle through the registered
// buffer read) plus a setup and a fold step; no input is taken then. A finish
// pads the buffer one byte per cycle, paused while a block compresses (one or
// two blocks in all), then delivers 16 digest bytes, one per output transfer.
module modified_md5_hash_engine_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       op,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      digest_byte,
  output logic            digest_last
);
  import mmd5_pkg::*;
  `include "assert_macros.svh"

  state_t state, state_next, after_blk, after_blk_next;
  logic [31:0] h [4];
  logic [60:0] count;
  logic [63:0] bits;
  logic [5:0]  rnd;
  logic        rnd_pre;
  logic [3:0]  obyte;
  logic [2:0]  lidx;
  logic        acc;
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;
  logic [31:0] word, a, b, c, d;
  rnd_ctl_t    ctl;
  logic        step;

  assign acc = in_valid && in_ready;
  assign wr_addr = count[5:0];

  always_comb begin
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    wr_en = 1'b0;
    wr_data = data_byte;
    unique case (state)
      ST_IDLE: begin
        wr_en = acc && (op == OP_ABSORB);
      end
      ST_PAD: begin
        wr_en = 1'b1;
        wr_data = (lidx == 3'd0 && bits[63]) ? PAD_FIRST : 8'h00;
      end
      ST_LEN: begin
        wr_en = 1'b1;
        wr_data = bits[8*lidx +: 8];
      end
      default: ;
    endcase
  end

  // bits[63] marks that the first pad byte is still to be written
  always_comb begin
    state_next = state;
    after_blk_next = after_blk;
    unique case (state)
      ST_IDLE: if (acc) begin
        if (op == OP_FINISH) state_next = ST_PAD;
        else if (count[5:0] == 6'd63) begin
          state_next = ST_ROUND; after_blk_next = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (count[5:0] == 6'd55) state_next = ST_LEN;
        else if (count[5:0] == 6'd63) begin
          state_next = ST_ROUND; after_blk_next = ST_PAD;
        end
      end
      ST_LEN: if (lidx == 3'd7) begin
        state_next = ST_ROUND; after_blk_next = ST_OUT;
      end
      ST_ROUND: if (!rnd_pre && rnd == 6'd63) state_next = ST_FOLD;
      ST_FOLD: state_next = after_blk;
      ST_OUT: if (out_ready && obyte == 4'd15) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign ctl.start = (state != ST_ROUND) && (state_next == ST_ROUND);
  assign ctl.round = rnd;
  assign step = (state == ST_ROUND) && !rnd_pre;

  mmd5_buf u_buf (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(word_sel(rnd_pre ? 6'd0 : 6'(rnd + 6'd1))), .rd_data(word)
  );

  mmd5_round u_round (
    .clk(clk), .ctl(ctl), .step(step),
    .init_a(h[0]), .init_b(h[1]), .init_c(h[2]), .init_d(h[3]),
    .word(word), .a(a), .b(b), .c(c), .d(d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      after_blk <= ST_IDLE;
      count <= '0;
      obyte <= '0;
      lidx <= '0;
      rnd <= '0;
      rnd_pre <= 1'b0;
      for (int i = 0; i < 4; i++) h[i] <= INIT_W[i];
    end else begin
      state <= state_next;
      after_blk <= after_blk_next;
      if (wr_en && state != ST_LEN) count <= count + 61'd1;
      if (state == ST_IDLE && acc && op == OP_FINISH) begin
        bits <= {1'b1, count, 2'b00};
        lidx <= '0;
      end
      if (state == ST_PAD) begin
        if (count[5:0] == 6'd55) begin
          // The marker leaves; the stored count moves into bit-count position.
          bits <= {bits[62:2], 3'b000};
        end else begin
          bits[63] <= 1'b0;
        end
      end
      if (state == ST_LEN) begin
        lidx <= lidx + 3'd1;
        count[5:0] <= count[5:0] + 6'd1;
      end
      if (ctl.start) begin
        rnd <= '0; rnd_pre <= 1'b1;
      end else if (state == ST_ROUND) begin
        rnd_pre <= 1'b0;
        if (!rnd_pre) rnd <= rnd + 6'd1;
      end
      if (state == ST_FOLD) begin
        h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c; h[3] <= h[3] + d;
      end
      if (state == ST_OUT && out_ready) begin
        obyte <= obyte + 4'd1;
        if (obyte == 4'd15) begin
          for (int i = 0; i < 4; i++) h[i] <= INIT_W[i];
          count <= '0;
        end
      end
    end
  end

  assign digest_byte = h[obyte[3:2]][8*obyte[1:0] +: 8];
  assign digest_last = (obyte == 4'd15);

  `CHK_IMPL(a_ready_idle, clk, rst, in_ready, !out_valid)
  `CHK_NEXT(a_last_ends, clk, rst, out_valid && out_ready && digest_last, in_ready)
  `CHK_IMPL(a_no_write_round, clk, rst, state == ST_ROUND, !wr_en)
endmodule
`default_nettype wire

>>> test/modified_md5_hash_engine_unit_check.sv
`default_nettype none
module modified_md5_hash_engine_unit_check (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic       op,
  input  wire logic [7:0] data_byte,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] digest_byte,
  input  wire logic       digest_last,
  output int              errors,
  output int              pending,
  output int              digests_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import mmd5_pkg::*;

  typedef struct packed {
    logic [7:0] dbyte;
    logic       last;
  } digest_beat_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'hc76aa478, 32'hf8c7b756, 32'h242070db, 32'hc1bdceee,
    32'he57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int SHIFTS [16] = '{9, 14, 19, 24, 7, 11, 16, 22, 6, 13, 18, 25,
    8, 12, 17, 23};

  logic [31:0]  chain [4];
  logic [7:0]   blk [64];
  logic [60:0]  msg_len;
  digest_beat_t digest_q [$];

  function automatic logic [31:0] rol(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic restart_chain();
    foreach (chain[i]) chain[i] = INIT_W[i];
    msg_len = '0;
  endtask

  task automatic compress_block();
    logic [31:0] a, b, c, d, f, t;
    logic [31:0] w [16];
    int g;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin f = (b & c) | ((~b & d) ^ c); g = r; end
        1: begin f = (b & d) | ((c & ~d) ^ b); g = (1 + 5 * r) % 16; end
        2: begin f = b ^ c ^ d ^ (b & c);      g = (5 + 3 * r) % 16; end
        default: begin f = c ^ (b | ~d) ^ d;   g = (7 * r) % 16; end
      endcase
      t = b + rol(a + f + w[g] + K_TAB[r], SHIFTS[(r / 16) * 4 + r % 4]);
      a = d; d = c; c = b; b = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic take_byte(input logic [7:0] v);
    int idx;
    idx = int'(msg_len[5:0]);
    blk[idx] = v;
    msg_len = msg_len + 1'b1;
    if (idx == 63) compress_block();
  endtask

  task automatic finish_message();
    logic [63:0] bits;
    bits = {msg_len, 3'b000};
    take_byte(PAD_FIRST);
    while (msg_len[5:0] != 6'd56) take_byte(8'h00);
    for (int i = 0; i < 8; i++) take_byte(bits[8*i +: 8]);
    for (int i = 0; i < 16; i++)
      digest_q.push_back(digest_beat_t'{dbyte: chain[i / 4][8 * (i % 4) +: 8],
        last: i == 15});
    restart_chain();
  endtask

  always @(posedge clk) begin
    digest_beat_t exp_beat;
    int err_inc;
    err_inc = 0;
    if (rst) begin
      restart_chain();
      digest_q.delete();
      errors <= 0;
      digests_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $error("digest transfer with nothing expected: digest_byte %h", digest_byte);
          err_inc++;
        end else begin
          exp_beat = digest_q.pop_front();
          if (digest_byte !== exp_beat.dbyte) begin
            $error("digest_byte: expected %h, got %h", exp_beat.dbyte, digest_byte);
            err_inc++;
          end
          if (digest_last !== exp_beat.last) begin
            $error("digest_last: expected %b, got %b", exp_beat.last, digest_last);
            err_inc++;
          end
          if (exp_beat.last) digests_seen <= digests_seen + 1;
        end
      end
      if (in_valid && in_ready) begin
        if (op == OP_FINISH) finish_message();
        else take_byte(data_byte);
      end
      errors <= errors + err_inc;
    end
    pending = digest_q.size();
  end
endmodule
`default_nettype wire

>>> test/modified_md5_hash_engine_unit_test.sv
`default_nettype none
module modified_md5_hash_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mmd5_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       op = OP_ABSORB;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] digest_byte;
  logic       digest_last;
  int         errors;
  int         pending;
  int         digests_seen;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         bytes_sent = 0;

  always #6 clk = ~clk;

  modified_md5_hash_engine_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .data_byte(data_byte), .out_valid(out_valid), .out_ready(out_ready),
    .digest_byte(digest_byte), .digest_last(digest_last));

  modified_md5_hash_engine_unit_check checker_i (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .data_byte(data_byte), .out_valid(out_valid), .out_ready(out_ready),
    .digest_byte(digest_byte), .digest_last(digest_last), .errors(errors),
    .pending(pending), .digests_seen(digests_seen));

  always @(posedge clk)
    if (!rst) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Presents one item, with random idle cycles before it, and holds it until
  // the transfer happens.
  task automatic send_item(input logic o, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_message(input int len, input bit walk);
    for (int i = 0; i < len; i++)
      send_item(OP_ABSORB, walk ? 8'(i * 37 + 1) : 8'($urandom_range(255)));
    send_item(OP_FINISH, 8'($urandom_range(255)));
  endtask

  initial begin
    int len;
    int bound_len [4];
    bound_len = '{55, 56, 63, 64};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Empty message, a single byte, all-ones and all-zeros bytes.
    send_item(OP_FINISH, 8'hff);
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_ABSORB, 8'hff);
    send_item(OP_ABSORB, 8'haa);
    send_item(OP_ABSORB, 8'h55);
    send_item(OP_FINISH, 8'h5a);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      // Lengths around the padding boundary, some forcing a second block,
      // then a short random message.
      send_message(bound_len[phase], phase == 0);
      len = $urandom_range(6);
      send_message(len, 1'b0);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d input transfers and %0d digests, incl. empty and two-block pads.",
      bytes_sent, digests_seen);
    if (errors == 0) begin
      $display("PASS modified_md5_hash_engine_unit");
    end else begin
      $display("FAIL modified_md5_hash_engine_unit");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL modified_md5_hash_engine_unit");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/mmd5_pkg.sv
rtl/mmd5_buf.sv
rtl/mmd5_round.sv
rtl/modified_md5_hash_engine_unit.sv
test/modified_md5_hash_engine_unit_check.sv
test/modified_md5_hash_engine_unit_test.sv
